[rtl/arpc_pkg.sv]
package arpc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned STATUS_W    = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_HOST_IP       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOST_IP_VALID = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBNET_MASK   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GATEWAY_IP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GATEWAY_VALID = 3'd4;

  localparam logic [IP_W-1:0] DEFAULT_MASK = 32'hFFFF_FF00;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_HOST  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LEARNED  = 3'd4;

  // Input kinds.
  localparam logic KIND_LEARN   = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  // How an item finishes.
  typedef enum logic [1:0] {
    FIN_FAIL,
    FIN_HIT,
    FIN_MISS,
    FIN_LEARN
  } fin_t;

  typedef struct packed {
    logic load;
    logic route;
    logic scan;
    logic move_rd;
    logic move_wr;
    logic append;
    logic mac_update;
    logic finish;
    fin_t fin;
  } dp_cmd_t;

  typedef struct packed {
    logic route_ok;
    logic is_learn;
    logic hit;
    logic miss;
    logic full;
  } dp_sts_t;

endpackage

[rtl/arpc_ctrl.sv]
module arpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  arpc_pkg::dp_sts_t sts,
  output arpc_pkg::dp_cmd_t cmd
);

  import arpc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ROUTE   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_MOVE_RD = 6'b001000,
    S_MOVE_WR = 6'b010000,
    S_LAST    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fin    = FIN_FAIL;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_ROUTE;
        end
      end
      S_ROUTE: begin
        cmd.route = 1'b1;
        if (sts.route_ok) begin
          state_next = S_SCAN;
        end else begin
          cmd.finish = 1'b1;
          cmd.fin    = FIN_FAIL;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
          if (sts.is_learn) begin
            cmd.mac_update = 1'b1;
            cmd.fin        = FIN_LEARN;
          end else begin
            cmd.fin = FIN_HIT;
          end
        end else if (sts.miss) begin
          if (!sts.is_learn) begin
            cmd.finish = 1'b1;
            cmd.fin    = FIN_MISS;
            state_next = S_IDLE;
          end else if (sts.full) begin
            state_next = S_MOVE_RD;
          end else begin
            cmd.append = 1'b1;
            cmd.finish = 1'b1;
            cmd.fin    = FIN_LEARN;
            state_next = S_IDLE;
          end
        end
      end
      S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_next  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next  = S_LAST;
      end
      S_LAST: begin
        cmd.append = 1'b1;
        cmd.finish = 1'b1;
        cmd.fin    = FIN_LEARN;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result always returns the controller to idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !busy)
    else $error("controller still busy after finishing an item");

endmodule

[rtl/arpc_dp.sv]
module arpc_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [arpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               kind,
  input  logic [arpc_pkg::IP_W-1:0]          ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]         mac_address,
  input  arpc_pkg::dp_cmd_t                  cmd,
  output arpc_pkg::dp_sts_t                  sts,
  output logic                               result_valid,
  output logic [arpc_pkg::STATUS_W-1:0]      status,
  output logic [arpc_pkg::IP_W-1:0]          route_hop,
  output logic [arpc_pkg::MAC_W-1:0]         mac_out,
  output logic                               release_pending
);

  import arpc_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   LAST_SLOT   = IDX_W'(TABLE_DEPTH - 1);

  // Configuration registers.
  logic [IP_W-1:0] host_ip;
  logic            host_ip_valid;
  logic [IP_W-1:0] subnet_mask;
  logic [IP_W-1:0] gateway_ip;
  logic            gateway_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_ip       <= '0;
      host_ip_valid <= 1'b0;
      subnet_mask   <= DEFAULT_MASK;
      gateway_ip    <= '0;
      gateway_valid <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HOST_IP:       host_ip       <= cfg_data;
        REG_HOST_IP_VALID: host_ip_valid <= cfg_data[0];
        REG_SUBNET_MASK:   subnet_mask   <= cfg_data;
        REG_GATEWAY_IP:    gateway_ip    <= cfg_data;
        REG_GATEWAY_VALID: gateway_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic             in_kind;
  logic [IP_W-1:0]  in_ip;
  logic [MAC_W-1:0] in_mac;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_kind <= kind;
      in_ip   <= ip_address;
      in_mac  <= mac_address;
    end
  end

  // Routing: the key is the address searched for in the table. A routing
  // failure finishes in the routing cycle itself, so its status is taken
  // straight from the routing logic.
  logic                route_ok;
  logic [IP_W-1:0]     route_key;
  logic [STATUS_W-1:0] route_fail;
  logic [IP_W-1:0]     key;

  always_comb begin
    route_ok   = 1'b1;
    route_key  = in_ip;
    route_fail = ST_NO_ROUTE;
    if (in_kind == KIND_RESOLVE) begin
      if (!host_ip_valid) begin
        route_ok   = 1'b0;
        route_fail = ST_NO_HOST;
      end else if ((host_ip & subnet_mask) == (in_ip & subnet_mask)) begin
        route_key = in_ip;
      end else if (gateway_valid) begin
        route_key = gateway_ip;
      end else begin
        route_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.route) begin
      key <= route_key;
    end
  end

  // Table store and scan pipeline.
  logic [IP_W-1:0]    entry_ip  [TABLE_DEPTH];
  logic [MAC_W-1:0]   entry_mac [TABLE_DEPTH];
  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] scan_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_valid;
  logic [IP_W-1:0]    ip_q;
  logic [MAC_W-1:0]   mac_q;
  logic               issue;
  logic               full;
  logic               hit;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   append_addr;
  logic [IP_W-1:0]    wr_ip;
  logic [MAC_W-1:0]   wr_mac;
  logic               ip_we;
  logic               mac_we;

  assign issue       = (scan_idx < entry_count);
  assign full        = (entry_count == DEPTH_COUNT);
  assign hit         = rd_valid && (ip_q == key);
  assign rd_addr     = cmd.move_rd ? LAST_SLOT : scan_idx[IDX_W-1:0];
  assign append_addr = full ? LAST_SLOT : entry_count[IDX_W-1:0];
  assign wr_addr     = cmd.move_wr ? '0 : (cmd.mac_update ? rd_idx : append_addr);
  assign wr_ip       = cmd.move_wr ? ip_q : key;
  assign wr_mac      = cmd.move_wr ? mac_q : in_mac;
  assign ip_we       = cmd.move_wr || cmd.append;
  assign mac_we      = cmd.move_wr || cmd.append || cmd.mac_update;

  always_ff @(posedge clk) begin
    if (ip_we) begin
      entry_ip[wr_addr] <= wr_ip;
    end
    if (mac_we) begin
      entry_mac[wr_addr] <= wr_mac;
    end
    ip_q  <= entry_ip[rd_addr];
    mac_q <= entry_mac[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      scan_idx    <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (cmd.route) begin
        scan_idx <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmd.append && !full) begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && issue) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
  end

  assign sts.route_ok = route_ok;
  assign sts.is_learn = (in_kind == KIND_LEARN);
  assign sts.hit      = hit;
  assign sts.miss     = !rd_valid && (scan_idx == entry_count);
  assign sts.full     = full;

  // Pending resolution slot and result register.
  logic            pending_active;
  logic [IP_W-1:0] pending_hop;
  logic            release_hit;

  assign release_hit = pending_active && (pending_hop == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_active <= 1'b0;
      pending_hop    <= '0;
    end else if (cmd.finish) begin
      if (cmd.fin == FIN_MISS) begin
        pending_active <= 1'b1;
        pending_hop    <= key;
      end else if (cmd.fin == FIN_LEARN && release_hit) begin
        pending_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status          <= route_fail;
      route_hop       <= '0;
      mac_out         <= '0;
      release_pending <= 1'b0;
      case (cmd.fin)
        FIN_FAIL: begin
          status <= route_fail;
        end
        FIN_HIT: begin
          status    <= ST_HIT;
          route_hop <= key;
          mac_out   <= mac_q;
        end
        FIN_MISS: begin
          status    <= ST_MISS;
          route_hop <= key;
        end
        FIN_LEARN: begin
          status <= ST_LEARNED;
          if (release_hit) begin
            release_pending <= 1'b1;
            mac_out         <= in_mac;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_COUNT)
    else $error("entry count beyond table depth");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.finish))
    else $error("result strobe without a finished item");

  a_miss_arms: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && cmd.fin == FIN_MISS) |=> (pending_active && pending_hop == $past(key)))
    else $error("miss did not arm the pending slot");

endmodule

[rtl/arp_cache_next_hop_resolver.sv]
// Channel   Handshake                      Payload
// input     start, accepted when !busy     kind, ip_address, mac_address
// config    cfg_write, cfg_index           cfg_data (32 bits, narrower registers use bit 0)
// result    result_valid, one-cycle strobe status, route_hop, mac_out, release_pending
//
// An item is first routed and then scans the table one entry per cycle through the
// registered read port of the address store; a routing failure ends in its routing cycle.
// A learn that appends to a full table then passes through the move-read, move-write and
// last states to move the last entry into slot 0 and write the new one into the last slot.
// The result strobe comes in the first cycle in which busy is low again.
// Reset is synchronous and active high; it resets the configuration registers, the entry
// count and the pending slot, while the table contents are left as they are.
// The receiver cannot stall.
module arp_cache_next_hop_resolver #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [arpc_pkg::IP_W-1:0]        ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]       mac_address,
  input  logic                             cfg_write,
  input  logic [arpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             result_valid,
  output logic [arpc_pkg::STATUS_W-1:0]    status,
  output logic [arpc_pkg::IP_W-1:0]        route_hop,
  output logic [arpc_pkg::MAC_W-1:0]       mac_out,
  output logic                             release_pending
);

  import arpc_pkg::*;

  // The controller sequences routing, the table scan and the writes; the datapath holds
  // the configuration, the table, the pending slot and the result register.
  dp_cmd_t cmd;
  dp_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  arpc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .ip_address      (ip_address),
    .mac_address     (mac_address),
    .cmd             (cmd),
    .sts             (sts),
    .result_valid    (result_valid),
    .status          (status),
    .route_hop       (route_hop),
    .mac_out         (mac_out),
    .release_pending (release_pending)
  );

endmodule

[sim/tb_arp_cache_next_hop_resolver.sv]
`timescale 1ns / 1ps

// Self-checking bench for the ARP cache and next-hop resolver.
//
// Every command transfer (start high while busy is low) is run through a
// behavioural copy of the cache kept here: the address table, the entry count,
// the single pending-resolution slot and the five routing registers. The copy
// yields exactly one expected result per command, which is queued. Each result
// strobe from the block is then compared field by field with the oldest queued
// expectation. The receiver cannot hold results off, so only the sender idles.
module tb_arp_cache_next_hop_resolver;
  import arpc_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 64;
  localparam int unsigned ADDR_POOL_SIZE = 96;
  // The longest busy stretch, a learn that scans a full table and then evicts,
  // and the longest sender gap both stay well below this limit, so a stretch of
  // quiet cycles this long without any transfer can only mean a hang.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IP_W-1:0]     route_hop;
    logic [MAC_W-1:0]    mac_out;
    logic                release_pending;
  } arp_outcome_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   kind;
  logic [IP_W-1:0]        ip_address;
  logic [MAC_W-1:0]       mac_address;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   result_valid;
  logic [STATUS_W-1:0]    status;
  logic [IP_W-1:0]        route_hop;
  logic [MAC_W-1:0]       mac_out;
  logic                   release_pending;

  // Our own view of the routing registers, updated as each write is issued.
  logic [IP_W-1:0] cfg_host_ip;
  logic            cfg_host_valid;
  logic [IP_W-1:0] cfg_mask;
  logic [IP_W-1:0] cfg_gateway;
  logic            cfg_gateway_valid;

  // Our own view of the cache contents and of the pending slot.
  logic [IP_W-1:0]  cache_ip  [TABLE_DEPTH];
  logic [MAC_W-1:0] cache_mac [TABLE_DEPTH];
  int unsigned      cache_entries;
  logic             pend_active;
  logic [IP_W-1:0]  pend_hop;

  // Addresses that most learns and resolves of one traffic phase are drawn from, so
  // that hits, updates and evictions are frequent rather than accidental.
  logic [IP_W-1:0] addr_pool [ADDR_POOL_SIZE];

  arp_outcome_t expected_outcomes[$];
  int unsigned  mismatches;
  int unsigned  quiet_cycles;

  arp_cache_next_hop_resolver #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .ip_address(ip_address),
    .mac_address(mac_address),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .status(status),
    .route_hop(route_hop),
    .mac_out(mac_out),
    .release_pending(release_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioural cache
  // ---------------------------------------------------------------------------

  // Lowest-indexed slot holding the address, or -1 when it is not cached.
  function automatic int find_slot(logic [IP_W-1:0] addr);
    for (int i = 0; i < int'(cache_entries); i++) begin
      if (cache_ip[i] == addr) return i;
    end
    return -1;
  endfunction

  // Works out the result of one command and advances the cache state with it.
  function automatic arp_outcome_t predict_outcome(logic cmd_kind, logic [IP_W-1:0] addr,
                                                   logic [MAC_W-1:0] mac);
    arp_outcome_t    res;
    int              slot;
    logic [IP_W-1:0] hop;
    res = '0;
    if (cmd_kind == KIND_LEARN) begin
      slot = find_slot(addr);
      if (slot < 0) begin
        // A full table gives up slot 0: the last entry moves there and the
        // new address takes the last slot.
        if (cache_entries >= TABLE_DEPTH) begin
          cache_entries = TABLE_DEPTH - 1;
          cache_ip[0]   = cache_ip[cache_entries];
          cache_mac[0]  = cache_mac[cache_entries];
        end
        slot = int'(cache_entries);
        cache_entries++;
        cache_ip[slot] = addr;
      end
      cache_mac[slot] = mac;
      res.status = ST_LEARNED;
      if (pend_active && pend_hop == addr) begin
        pend_active         = 1'b0;
        res.release_pending = 1'b1;
        res.mac_out         = mac;
      end
    end else if (!cfg_host_valid) begin
      res.status = ST_NO_HOST;
    end else if (((cfg_host_ip ^ addr) & cfg_mask) != '0 && !cfg_gateway_valid) begin
      res.status = ST_NO_ROUTE;
    end else begin
      // Locality is a plain masked compare, whatever shape the mask has.
      hop = (((cfg_host_ip ^ addr) & cfg_mask) == '0) ? addr : cfg_gateway;
      res.route_hop = hop;
      slot = find_slot(hop);
      if (slot >= 0) begin
        res.status  = ST_HIT;
        res.mac_out = cache_mac[slot];
      end else begin
        // A second miss simply takes over the pending slot.
        res.status  = ST_MISS;
        pend_active = 1'b1;
        pend_hop    = hop;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [MAC_W-1:0] want, logic [MAC_W-1:0] got);
    if (got !== want) note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Each strobe is a transfer in its own right, since the block cannot be
  // held off; it is matched against the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    arp_outcome_t want;
    if (!rst && result_valid) begin
      if (expected_outcomes.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d route_hop 0x%0h", status,
                               route_hop));
      end else begin
        want = expected_outcomes.pop_front();
        check_field("status", want.status, status);
        check_field("route_hop", want.route_hop, route_hop);
        check_field("mac_out", want.mac_out, mac_out);
        check_field("release_pending", want.release_pending, release_pending);
      end
    end
  end

  // Ends the run if neither a command nor a result is transferred for too long.
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("** arp_cache_next_hop_resolver: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Presents one command and holds it until the block takes it. Inputs move on
  // the falling edge; busy is sampled on the rising edge that does the transfer.
  task automatic send_item(logic cmd_kind, logic [IP_W-1:0] addr, logic [MAC_W-1:0] mac);
    @(negedge clk);
    start       <= 1'b1;
    kind        <= cmd_kind;
    ip_address  <= addr;
    mac_address <= mac;
    do @(posedge clk); while (busy);
    expected_outcomes.push_back(predict_outcome(cmd_kind, addr, mac));
  endtask

  // Sender gap: start is low and the payload wanders, which must be ignored.
  task automatic idle_gap(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start       <= 1'b0;
      kind        <= 1'($urandom);
      ip_address  <= $urandom;
      mac_address <= random_mac();
    end
  endtask

  // Stops sending and waits until every outstanding result has come back. As
  // every command yields a result, the block is then idle.
  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_HOST_IP:       cfg_host_ip       = data;
      REG_HOST_IP_VALID: cfg_host_valid    = data[0];
      REG_SUBNET_MASK:   cfg_mask          = data;
      REG_GATEWAY_IP:    cfg_gateway       = data;
      REG_GATEWAY_VALID: cfg_gateway_valid = data[0];
      default: ;
    endcase
  endtask

  // Rewrites all five registers; the one-bit flags carry random upper bits,
  // which the block has to ignore.
  task automatic set_routing(logic [IP_W-1:0] host, logic host_ok, logic [IP_W-1:0] mask,
                             logic [IP_W-1:0] gateway, logic gateway_ok);
    wait_until_drained();
    write_reg(REG_HOST_IP, host);
    write_reg(REG_HOST_IP_VALID, {31'($urandom), host_ok});
    write_reg(REG_SUBNET_MASK, mask);
    write_reg(REG_GATEWAY_IP, gateway);
    write_reg(REG_GATEWAY_VALID, {31'($urandom), gateway_ok});
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Straight after reset there is no host address: resolves are refused, yet
  // learning still works.
  task automatic test_no_host_address();
    send_item(KIND_RESOLVE, '0, '0);
    send_item(KIND_LEARN, 32'hC0A8_0105, '0);
    send_item(KIND_RESOLVE, '1, '1);
  endtask

  task automatic test_learn_and_hit();
    set_routing(32'hC0A8_0101, 1'b1, DEFAULT_MASK, '0, 1'b0);
    send_item(KIND_RESOLVE, 32'hC0A8_0105, '0);
    send_item(KIND_LEARN, 32'hC0A8_0105, '1);
    send_item(KIND_RESOLVE, 32'hC0A8_0105, random_mac());
    send_item(KIND_LEARN, '0, 48'hA5A5_5A5A_A5A5);
  endtask

  // Local, gateway and unroutable destinations under several masks, including
  // an empty mask, a full mask and a non-contiguous one.
  task automatic test_routing();
    send_item(KIND_RESOLVE, 32'h0A00_0001, '0);
    set_routing(32'hC0A8_0101, 1'b1, DEFAULT_MASK, '1, 1'b1);
    send_item(KIND_RESOLVE, 32'h0A00_0001, '0);
    send_item(KIND_LEARN, '1, 48'h0123_4567_89AB);
    send_item(KIND_RESOLVE, 32'h0808_0808, '0);
    set_routing(32'hC0A8_0101, 1'b1, '0, '1, 1'b1);
    send_item(KIND_RESOLVE, 32'h0808_0808, '0);
    set_routing(32'hC0A8_0101, 1'b1, 32'hF0F0_F0F0, '1, 1'b1);
    send_item(KIND_RESOLVE, 32'hC0AF_0E0F, '0);
    send_item(KIND_RESOLVE, 32'hD0A8_0101, '0);
    set_routing('1, 1'b1, '1, '0, 1'b0);
    send_item(KIND_RESOLVE, '1, '0);
  endtask

  // A second miss takes over the pending slot; only a learn of the latest
  // pending hop releases it, and only once.
  task automatic test_pending_slot();
    set_routing(32'hC0A8_0101, 1'b1, DEFAULT_MASK, '0, 1'b0);
    send_item(KIND_RESOLVE, 32'hC0A8_0110, '0);
    send_item(KIND_RESOLVE, 32'hC0A8_0111, '0);
    send_item(KIND_LEARN, 32'hC0A8_0110, 48'h0000_0000_0110);
    send_item(KIND_LEARN, 32'hC0A8_0111, 48'hFFFF_0000_0111);
    send_item(KIND_LEARN, 32'hC0A8_0111, 48'hFFFF_0000_0112);
    send_item(KIND_RESOLVE, 32'hC0A8_0111, '0);
  endtask

  // Writes to indexes past the register list must change nothing, and only
  // bit 0 of a flag register counts.
  task automatic test_register_decode();
    wait_until_drained();
    for (int i = REG_GATEWAY_VALID + 1; i < 2 ** CFG_INDEX_W; i++) begin
      write_reg(CFG_INDEX_W'(i), $urandom);
    end
    write_reg(REG_HOST_IP_VALID, 32'hFFFF_FFFE);
    send_item(KIND_RESOLVE, 32'hC0A8_0111, '0);
    wait_until_drained();
    write_reg(REG_HOST_IP_VALID, 32'h8000_0001);
    write_reg(REG_GATEWAY_VALID, 32'hFFFF_FFFE);
    send_item(KIND_RESOLVE, 32'h0A0A_0A0A, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  task automatic fill_addr_pool();
    for (int i = 0; i < ADDR_POOL_SIZE; i++) begin
      if (i == 0) addr_pool[i] = cfg_gateway;
      else if (i < ADDR_POOL_SIZE / 2) addr_pool[i] = (cfg_host_ip & cfg_mask) |
                                                      ($urandom & ~cfg_mask);
      else addr_pool[i] = $urandom;
    end
  endtask

  function automatic logic [IP_W-1:0] pick_addr(int unsigned pool_pct);
    if ($urandom_range(99) < pool_pct) return addr_pool[$urandom_range(ADDR_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Bursts of commands with random gaps, back-to-back stretches, and now and
  // then a full drain. The pool holds more addresses than the table, so the
  // table fills and evicts during the first phase and stays full afterwards.
  task automatic run_traffic(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    sent = 0;
    fill_addr_pool();
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < int'(burst) && sent < count; b++) begin
        pick = $urandom_range(99);
        if (pick < 8 && pend_active) send_item(KIND_LEARN, pend_hop, random_mac());
        else if (pick < 45) send_item(KIND_LEARN, pick_addr(85), random_mac());
        else send_item(KIND_RESOLVE, pick_addr(75), random_mac());
        sent++;
      end
      pick = $urandom_range(99);
      if (pick < 10) wait_until_drained();
      else if (pick >= 35) idle_gap($urandom_range(1, 12));
    end
  endtask

  task automatic test_random_traffic();
    logic [IP_W-1:0] prefix_mask;
    for (int phase = 0; phase < 6; phase++) begin
      prefix_mask = '1 << $urandom_range(0, 32);
      case (phase)
        0: set_routing($urandom, 1'b1, DEFAULT_MASK, $urandom, 1'b1);
        1: set_routing($urandom, 1'b1, '0, $urandom, 1'b0);
        2: set_routing('1, 1'b1, '1, $urandom, 1'b1);
        3: set_routing('0, 1'b1, $urandom, $urandom, 1'($urandom));
        4: set_routing($urandom, 1'b0, DEFAULT_MASK, $urandom, 1'b0);
        default: set_routing($urandom, 1'b1, prefix_mask, $urandom, 1'($urandom));
      endcase
      run_traffic(phase == 4 ? 100 : 265);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    kind              = KIND_LEARN;
    ip_address        = '0;
    mac_address       = '0;
    cfg_write         = 1'b0;
    cfg_index         = REG_HOST_IP;
    cfg_data          = '0;
    cfg_host_ip       = '0;
    cfg_host_valid    = 1'b0;
    cfg_mask          = DEFAULT_MASK;
    cfg_gateway       = '0;
    cfg_gateway_valid = 1'b0;
    cache_entries     = 0;
    pend_active       = 1'b0;
    pend_hop          = '0;
    mismatches        = 0;
    quiet_cycles      = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_no_host_address();
    test_learn_and_hit();
    test_routing();
    test_pending_slot();
    test_register_decode();
    test_random_traffic();

    // Let any stray strobe show itself before the verdict.
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_outcomes.size()));
    end

    if (mismatches == 0) begin
      $display("** arp_cache_next_hop_resolver: PASSED **");
    end else begin
      $display("** arp_cache_next_hop_resolver: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_dp.sv
rtl/arp_cache_next_hop_resolver.sv
sim/tb_arp_cache_next_hop_resolver.sv
